// ===== rtl/assert_macros.svh =====
// Assertion macros for RTL that checks its own behavior; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clk edge, off while rst_n is low.
`define TCW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same, with a name for the implication to read better at the use site.
`define TCW_ASSERT_IMPLY(label, lhs, rhs, msg) \
    `TCW_ASSERT(label, (lhs) |-> (rhs), msg)

`endif

// ===== rtl/tcw_pkg.sv =====
// Shared types, constants and the control store of the text console writer.
package tcw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int ATTR_W = 8;
    localparam int CELL_DATA_W = 16;
    localparam int STEP_W = 5;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE     = 2'd0,
        OP_BACKSPACE = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_READ      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        WD_CHAR  = 2'd0,
        WD_BLANK = 2'd1,
        WD_COPY  = 2'd2
    } wsel_t;

    typedef enum logic {
        WA_CURSOR = 1'b0,
        WA_PTR    = 1'b1
    } waddr_t;

    typedef enum logic {
        RA_SHIFT = 1'b0,
        RA_INDEX = 1'b1
    } raddr_t;

    typedef enum logic [1:0] {
        PTR_HOLD = 2'd0,
        PTR_CLR  = 2'd1,
        PTR_INC  = 2'd2
    } ptr_op_t;

    typedef enum logic [2:0] {
        CUR_HOLD      = 3'd0,
        CUR_COL_INC   = 3'd1,
        CUR_COL_CLR   = 3'd2,
        CUR_COL_DEC   = 3'd3,
        CUR_ROW_INC   = 3'd4,
        CUR_HOME      = 3'd5,
        CUR_WRAP_BACK = 3'd6
    } cur_op_t;

    typedef enum logic [3:0] {
        C_NEVER         = 4'd0,
        C_ALWAYS        = 4'd1,
        C_NEWLINE       = 4'd2,
        C_COL_LAST      = 4'd3,
        C_ROW_LAST      = 4'd4,
        C_PTR_MORE_COPY = 4'd5,
        C_PTR_MORE      = 4'd6,
        C_ORIGIN        = 4'd7,
        C_COL_ZERO      = 4'd8,
        C_INIT          = 4'd9,
        C_OUT_BUSY      = 4'd10
    } cond_t;

    typedef struct packed {
        logic    dispatch;
        logic    emit;
        logic    mem_we;
        wsel_t   wsel;
        waddr_t  waddr;
        logic    mem_re;
        raddr_t  raddr;
        ptr_op_t ptr_op;
        cur_op_t cur_op;
        logic    cell_load;
        logic    clr_init;
        cond_t   cond;
        step_t   target;
    } ucode_t;

    typedef struct packed {
        ucode_t uc;
        logic   accept;
    } ctl_t;

    typedef struct packed {
        logic newline;
        logic col_last;
        logic row_last;
        logic col_zero;
        logic origin;
        logic ptr_more_copy;
        logic ptr_more;
        logic init;
        logic out_busy;
    } status_t;

    // Control store layout
    localparam step_t ST_CLR0  = 5'd0;
    localparam step_t ST_CLR1  = 5'd1;
    localparam step_t ST_CLR2  = 5'd2;
    localparam step_t ST_DONE  = 5'd3;
    localparam step_t ST_IDLE  = 5'd4;
    localparam step_t ST_WR0   = 5'd5;
    localparam step_t ST_WR1   = 5'd6;
    localparam step_t ST_WR2   = 5'd7;
    localparam step_t ST_NL0   = 5'd8;
    localparam step_t ST_NL1   = 5'd9;
    localparam step_t ST_SCR0  = 5'd10;
    localparam step_t ST_SCR1  = 5'd11;
    localparam step_t ST_SCR2  = 5'd12;
    localparam step_t ST_SCR3  = 5'd13;
    localparam step_t ST_SCR4  = 5'd14;
    localparam step_t ST_BS0   = 5'd15;
    localparam step_t ST_BS1   = 5'd16;
    localparam step_t ST_BS2   = 5'd17;
    localparam step_t ST_BS3   = 5'd18;
    localparam step_t ST_BS4   = 5'd19;
    localparam step_t ST_RD0   = 5'd20;
    localparam step_t ST_RD1   = 5'd21;

    function automatic ucode_t ucode_word(step_t s);
        ucode_t w;
        w = '0;
        case (s)
            ST_CLR0:
            begin
                w.ptr_op = PTR_CLR;
                w.cur_op = CUR_HOME;
            end
            ST_CLR1:
            begin
                w.mem_we = 1'b1;
                w.wsel   = WD_BLANK;
                w.waddr  = WA_PTR;
                w.ptr_op = PTR_INC;
                w.cond   = C_PTR_MORE;
                w.target = ST_CLR1;
            end
            ST_CLR2:
            begin
                // the power-up pass ends here without a result
                w.clr_init = 1'b1;
                w.cond     = C_INIT;
                w.target   = ST_IDLE;
            end
            ST_DONE:
            begin
                w.emit   = 1'b1;
                w.cond   = C_OUT_BUSY;
                w.target = ST_DONE;
            end
            ST_IDLE:
            begin
                w.dispatch = 1'b1;
            end
            ST_WR0:
            begin
                w.cond   = C_NEWLINE;
                w.target = ST_NL0;
            end
            ST_WR1:
            begin
                w.mem_we = 1'b1;
                w.wsel   = WD_CHAR;
                w.waddr  = WA_CURSOR;
                w.cond   = C_COL_LAST;
                w.target = ST_NL0;
            end
            ST_WR2:
            begin
                w.cur_op = CUR_COL_INC;
                w.cond   = C_ALWAYS;
                w.target = ST_DONE;
            end
            ST_NL0:
            begin
                w.cur_op = CUR_COL_CLR;
                w.cond   = C_ROW_LAST;
                w.target = ST_SCR0;
            end
            ST_NL1:
            begin
                w.cur_op = CUR_ROW_INC;
                w.cond   = C_ALWAYS;
                w.target = ST_DONE;
            end
            ST_SCR0:
            begin
                w.ptr_op = PTR_CLR;
            end
            ST_SCR1:
            begin
                w.mem_re = 1'b1;
                w.raddr  = RA_SHIFT;
            end
            ST_SCR2:
            begin
                w.mem_we = 1'b1;
                w.wsel   = WD_COPY;
                w.waddr  = WA_PTR;
                w.ptr_op = PTR_INC;
                w.cond   = C_PTR_MORE_COPY;
                w.target = ST_SCR1;
            end
            ST_SCR3:
            begin
                w.mem_we = 1'b1;
                w.wsel   = WD_BLANK;
                w.waddr  = WA_PTR;
                w.ptr_op = PTR_INC;
                w.cond   = C_PTR_MORE;
                w.target = ST_SCR3;
            end
            ST_SCR4:
            begin
                w.cond   = C_ALWAYS;
                w.target = ST_DONE;
            end
            ST_BS0:
            begin
                w.cond   = C_ORIGIN;
                w.target = ST_DONE;
            end
            ST_BS1:
            begin
                w.cond   = C_COL_ZERO;
                w.target = ST_BS3;
            end
            ST_BS2:
            begin
                w.cur_op = CUR_COL_DEC;
                w.cond   = C_ALWAYS;
                w.target = ST_BS4;
            end
            ST_BS3:
            begin
                w.cur_op = CUR_WRAP_BACK;
            end
            ST_BS4:
            begin
                w.mem_we = 1'b1;
                w.wsel   = WD_BLANK;
                w.waddr  = WA_CURSOR;
                w.cond   = C_ALWAYS;
                w.target = ST_DONE;
            end
            ST_RD0:
            begin
                w.mem_re = 1'b1;
                w.raddr  = RA_INDEX;
            end
            ST_RD1:
            begin
                w.cell_load = 1'b1;
                w.cond      = C_ALWAYS;
                w.target    = ST_DONE;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic step_t dispatch_step(logic [OP_W-1:0] opcode);
        step_t s;
        s = ST_IDLE;
        case (op_t'(opcode))
            OP_WRITE:     s = ST_WR0;
            OP_BACKSPACE: s = ST_BS0;
            OP_CLEAR:     s = ST_CLR0;
            OP_READ:      s = ST_RD0;
            default:      s = ST_IDLE;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/tcw_sequencer.sv =====
// Step counter, control store lookup and next-step selection.
module tcw_sequencer
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    input  logic [tcw_pkg::OP_W-1:0]  opcode,
    input  tcw_pkg::status_t          status,
    output logic                      item_stall,
    output tcw_pkg::ctl_t             ctl
);

    tcw_pkg::step_t  step_reg;
    tcw_pkg::step_t  step_next;
    tcw_pkg::ucode_t uc;
    logic            accept;
    logic            cond_true;

    assign uc         = tcw_pkg::ucode_word(step_reg);
    assign accept     = item_valid && uc.dispatch;
    assign item_stall = !uc.dispatch;
    assign ctl.uc     = uc;
    assign ctl.accept = accept;

    always_comb
    begin
        unique case (uc.cond)
            tcw_pkg::C_NEVER:         cond_true = 1'b0;
            tcw_pkg::C_ALWAYS:        cond_true = 1'b1;
            tcw_pkg::C_NEWLINE:       cond_true = status.newline;
            tcw_pkg::C_COL_LAST:      cond_true = status.col_last;
            tcw_pkg::C_ROW_LAST:      cond_true = status.row_last;
            tcw_pkg::C_PTR_MORE_COPY: cond_true = status.ptr_more_copy;
            tcw_pkg::C_PTR_MORE:      cond_true = status.ptr_more;
            tcw_pkg::C_ORIGIN:        cond_true = status.origin;
            tcw_pkg::C_COL_ZERO:      cond_true = status.col_zero;
            tcw_pkg::C_INIT:          cond_true = status.init;
            tcw_pkg::C_OUT_BUSY:      cond_true = status.out_busy;
            default:                  cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        if (uc.dispatch)
        begin
            step_next = accept ? tcw_pkg::dispatch_step(opcode) : step_reg;
        end
        else if (cond_true)
        begin
            step_next = uc.target;
        end
        else
        begin
            step_next = step_reg + tcw_pkg::step_t'(1);
        end
    end

    // Reset starts the blanking pass over the cell store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= tcw_pkg::ST_CLR0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/tcw_datapath.sv =====
// Cursor, sweep pointer, cell store, attribute register and result register.
module tcw_datapath
#(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  tcw_pkg::ctl_t                    ctl,
    input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
    input  logic [tcw_pkg::IDX_W-1:0]        cell_index,
    input  logic                             text_attribute_we,
    input  logic [tcw_pkg::ATTR_W-1:0]       text_attribute,
    input  logic                             result_stall,
    output tcw_pkg::status_t                 status,
    output logic                             result_valid,
    output logic [tcw_pkg::IDX_W-1:0]        cursor_pos,
    output logic [tcw_pkg::CELL_DATA_W-1:0]  cell_value
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int CELL_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CMP_W  = ((CELL_W > tcw_pkg::IDX_W) ? CELL_W : tcw_pkg::IDX_W) + 1;

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [CELL_W-1:0] PTR_END   = CELL_W'(CELLS - 1);
    localparam logic [CELL_W-1:0] COPY_END  = CELL_W'(CELLS - COLUMNS - 1);
    localparam logic [CELL_W-1:0] ROW_STEP  = CELL_W'(COLUMNS);
    localparam logic [CMP_W-1:0]  CELLS_CMP = CMP_W'(CELLS);

    logic [tcw_pkg::CELL_DATA_W-1:0] mem [CELLS];

    logic [COL_W-1:0]               col_reg, col_next;
    logic [ROW_W-1:0]               row_reg, row_next;
    logic [CELL_W-1:0]              ptr_reg, ptr_next;
    logic                           init_reg, init_next;
    logic [tcw_pkg::ATTR_W-1:0]     attr_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [tcw_pkg::CHAR_W-1:0]     char_reg;
    logic [tcw_pkg::IDX_W-1:0]      idx_reg;
    logic [tcw_pkg::CELL_DATA_W-1:0] cell_reg;
    logic [tcw_pkg::CELL_DATA_W-1:0] rdata_reg;
    logic [tcw_pkg::IDX_W-1:0]      pos_reg;
    logic [tcw_pkg::CELL_DATA_W-1:0] value_reg;

    tcw_pkg::ucode_t                uc;
    logic [CELL_W-1:0]              row_ext;
    logic [CELL_W-1:0]              cursor_lin;
    logic [CMP_W-1:0]               idx_ext;
    logic                           idx_ok;
    logic [tcw_pkg::ATTR_W-1:0]     blank_attr;
    logic [CELL_W-1:0]              waddr;
    logic [CELL_W-1:0]              raddr;
    logic                           rd_en;
    logic [tcw_pkg::CELL_DATA_W-1:0] wdata;
    logic                           out_busy;
    logic                           emit;

    assign uc         = ctl.uc;
    assign row_ext    = CELL_W'(row_reg);
    assign cursor_lin = CELL_W'(row_ext * ROW_STEP) + CELL_W'(col_reg);
    assign idx_ext    = CMP_W'(idx_reg);
    assign idx_ok     = idx_ext < CELLS_CMP;
    // the power-up pass blanks with the reset attribute, whatever is written meanwhile
    assign blank_attr = init_reg ? tcw_pkg::RESET_ATTR : attr_reg;
    assign out_busy   = out_valid_reg && result_stall;
    assign emit       = uc.emit && !out_busy;

    assign status.newline       = char_reg == tcw_pkg::NEWLINE_CODE;
    assign status.col_last      = col_reg == COL_LAST;
    assign status.row_last      = row_reg == ROW_LAST;
    assign status.col_zero      = col_reg == '0;
    assign status.origin        = (col_reg == '0) && (row_reg == '0);
    assign status.ptr_more_copy = ptr_reg != COPY_END;
    assign status.ptr_more      = ptr_reg != PTR_END;
    assign status.init          = init_reg;
    assign status.out_busy      = out_busy;

    always_comb
    begin
        unique case (uc.waddr)
            tcw_pkg::WA_CURSOR: waddr = cursor_lin;
            tcw_pkg::WA_PTR:    waddr = ptr_reg;
            default:            waddr = ptr_reg;
        endcase
    end

    always_comb
    begin
        unique case (uc.raddr)
            tcw_pkg::RA_SHIFT: raddr = ptr_reg + ROW_STEP;
            tcw_pkg::RA_INDEX: raddr = idx_ext[CELL_W-1:0];
            default:           raddr = ptr_reg;
        endcase
        rd_en = uc.mem_re && ((uc.raddr == tcw_pkg::RA_SHIFT) || idx_ok);
    end

    always_comb
    begin
        unique case (uc.wsel)
            tcw_pkg::WD_CHAR:  wdata = {attr_reg, char_reg};
            tcw_pkg::WD_BLANK: wdata = {blank_attr, tcw_pkg::SPACE_CODE};
            tcw_pkg::WD_COPY:  wdata = rdata_reg;
            default:           wdata = rdata_reg;
        endcase
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        unique case (uc.cur_op)
            tcw_pkg::CUR_HOLD:
            begin
                col_next = col_reg;
            end
            tcw_pkg::CUR_COL_INC:
            begin
                col_next = col_reg + COL_W'(1);
            end
            tcw_pkg::CUR_COL_CLR:
            begin
                col_next = '0;
            end
            tcw_pkg::CUR_COL_DEC:
            begin
                col_next = col_reg - COL_W'(1);
            end
            tcw_pkg::CUR_ROW_INC:
            begin
                row_next = row_reg + ROW_W'(1);
            end
            tcw_pkg::CUR_HOME:
            begin
                col_next = '0;
                row_next = '0;
            end
            tcw_pkg::CUR_WRAP_BACK:
            begin
                col_next = COL_LAST;
                row_next = row_reg - ROW_W'(1);
            end
            default:
            begin
                col_next = col_reg;
            end
        endcase
    end

    always_comb
    begin
        unique case (uc.ptr_op)
            tcw_pkg::PTR_HOLD: ptr_next = ptr_reg;
            tcw_pkg::PTR_CLR:  ptr_next = '0;
            tcw_pkg::PTR_INC:  ptr_next = ptr_reg + CELL_W'(1);
            default:           ptr_next = ptr_reg;
        endcase
        init_next      = uc.clr_init ? 1'b0 : init_reg;
        out_valid_next = emit || out_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            ptr_reg       <= '0;
            init_reg      <= 1'b1;
            attr_reg      <= tcw_pkg::RESET_ATTR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            ptr_reg       <= ptr_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
            if (text_attribute_we)
            begin
                attr_reg <= text_attribute;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            char_reg <= char_code;
            idx_reg  <= cell_index;
            cell_reg <= '0;
        end
        else if (uc.cell_load)
        begin
            cell_reg <= idx_ok ? rdata_reg : '0;
        end
        if (emit)
        begin
            pos_reg   <= tcw_pkg::IDX_W'(CMP_W'(cursor_lin));
            value_reg <= cell_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (uc.mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign result_valid = out_valid_reg;
    assign cursor_pos   = pos_reg;
    assign cell_value   = value_reg;

endmodule

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: sequencer plus cell datapath.
//
// Text console engine with a COLUMNS x ROWS store of 16-bit cells (attribute
// byte high, character byte low) and a cursor, run by a microcoded sequencer
// that steps through one control word per cycle. Every accepted beat gives
// exactly one result beat with the linear cursor position and, for a read, the
// cell contents. The cell store has one write port, which moves one cell per
// cycle, with a read and a write step per copied cell during a scroll. A beat
// is taken only in the idle step, so input stalls until the previous beat has
// issued its result; the next beat can be taken in the cycle after that. After
// reset the block blanks the store with stall high; attribute writes are taken
// meanwhile. A finished result waits in an output register, and the next beat
// is accepted while it does; a further result holds in the done step until
// that register empties.
module text_console_writer
#(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [tcw_pkg::OP_W-1:0]         opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
    input  logic [tcw_pkg::IDX_W-1:0]        cell_index,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [tcw_pkg::IDX_W-1:0]        cursor_pos,
    output logic [tcw_pkg::CELL_DATA_W-1:0]  cell_value,
    input  logic                             text_attribute_we,
    input  logic [tcw_pkg::ATTR_W-1:0]       text_attribute
);

`include "assert_macros.svh"

    tcw_pkg::ctl_t    ctl;
    tcw_pkg::status_t status;

    tcw_sequencer u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .opcode     (opcode),
        .status     (status),
        .item_stall (item_stall),
        .ctl        (ctl)
    );

    tcw_datapath
    #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    )
    u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .char_code         (char_code),
        .cell_index        (cell_index),
        .text_attribute_we (text_attribute_we),
        .text_attribute    (text_attribute),
        .result_stall      (result_stall),
        .status            (status),
        .result_valid      (result_valid),
        .cursor_pos        (cursor_pos),
        .cell_value        (cell_value)
    );

    // an accepted beat always keeps the sequencer busy for the next cycle
    `TCW_ASSERT_IMPLY(a_busy_after_accept, item_valid && !item_stall, ##1 item_stall,
        "input taken again right after an accept")

    // a new result only leaves the done step, where input is stalled
    `TCW_ASSERT(a_result_from_done, $rose(result_valid) |-> $past(item_stall),
        "result raised while the sequencer was idle")

    `TCW_ASSERT(a_no_result_in_init, $past(!rst_n) |-> !result_valid,
        "result present right after reset")

endmodule

// ===== tb/text_console_checker.sv =====
`timescale 1ns / 100ps
// Checker for the text console writer: predicts every result beat and compares it.
module text_console_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    input  logic                             item_stall,
    input  logic [tcw_pkg::OP_W-1:0]         opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
    input  logic [tcw_pkg::IDX_W-1:0]        cell_index,
    input  logic                             result_valid,
    input  logic                             result_stall,
    input  logic [tcw_pkg::IDX_W-1:0]        cursor_pos,
    input  logic [tcw_pkg::CELL_DATA_W-1:0]  cell_value,
    input  logic                             text_attribute_we,
    input  logic [tcw_pkg::ATTR_W-1:0]       text_attribute,
    output int                               fail_count,
    output int                               pending,
    output int                               scroll_count
);
    import tcw_pkg::*;

    localparam int COLS  = COLUMNS_DEFAULT;
    localparam int LINES = ROWS_DEFAULT;
    localparam int CELLS = COLS * LINES;

    typedef struct packed {
        logic [IDX_W-1:0]       pos;
        logic [CELL_DATA_W-1:0] value;
    } console_result_t;

    logic [CELL_DATA_W-1:0] screen [0:CELLS-1];
    logic [6:0]             cur_col;
    logic [4:0]             cur_row;
    logic [ATTR_W-1:0]      attr;
    console_result_t        expected_q [$];
    console_result_t        oldest;
    console_result_t        fresh;

    task automatic report_mismatch(input string what);
        $display("checker: mismatch at %0t ns: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic blank_screen();
        int i;
        for (i = 0; i < CELLS; i++)
            screen[i] = {attr, SPACE_CODE};
        cur_col = '0;
        cur_row = '0;
    endtask

    // column 0 of the next row; off the bottom everything moves up one row
    task automatic advance_line();
        int i;
        cur_col = '0;
        cur_row = cur_row + 1'b1;
        if (cur_row >= LINES)
        begin
            for (i = 0; i < CELLS - COLS; i++)
                screen[i] = screen[i + COLS];
            for (i = CELLS - COLS; i < CELLS; i++)
                screen[i] = {attr, SPACE_CODE};
            cur_row = 5'(LINES - 1);
            scroll_count++;
        end
    endtask

    task automatic console_step(input op_t op, input logic [CHAR_W-1:0] ch,
                                input logic [IDX_W-1:0] idx, output console_result_t res);
        logic [CELL_DATA_W-1:0] value;
        value = '0;
        case (op)
            OP_WRITE:
            begin
                if (ch == NEWLINE_CODE)
                    advance_line();
                else
                begin
                    screen[cur_row * COLS + cur_col] = {attr, ch};
                    cur_col = cur_col + 1'b1;
                    if (cur_col >= COLS)
                        advance_line();
                end
            end
            OP_BACKSPACE:
            begin
                if (cur_col != 0 || cur_row != 0)
                begin
                    if (cur_col == 0)
                    begin
                        cur_row = cur_row - 1'b1;
                        cur_col = 7'(COLS - 1);
                    end
                    else
                        cur_col = cur_col - 1'b1;
                    screen[cur_row * COLS + cur_col] = {attr, SPACE_CODE};
                end
            end
            OP_CLEAR:
                blank_screen();
            OP_READ:
            begin
                if (idx < CELLS)
                    value = screen[idx];
            end
        endcase
        res.pos   = IDX_W'(cur_row * COLS + cur_col);
        res.value = value;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr = RESET_ATTR;
            blank_screen();
            expected_q.delete();
            pending = 0;
        end
        else
        begin
            if (text_attribute_we)
                attr = text_attribute;
            // compare before predicting, so a result never meets its own beat
            if (result_valid && !result_stall)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    oldest = expected_q.pop_front();
                    if (cursor_pos !== oldest.pos)
                        report_mismatch($sformatf("cursor_pos %0d, expected %0d",
                                                  cursor_pos, oldest.pos));
                    if (cell_value !== oldest.value)
                        report_mismatch($sformatf("cell_value %h, expected %h",
                                                  cell_value, oldest.value));
                end
            end
            if (item_valid && !item_stall)
            begin
                console_step(op_t'(opcode), char_code, cell_index, fresh);
                expected_q.push_back(fresh);
            end
            pending = expected_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the text console writer: clock, reset, stimulus and verdict.
module tb;
    import tcw_pkg::*;

    localparam int CYCLE_LIMIT = 40_000_000;
    localparam int ITEM_TARGET = 2000;
    localparam int CALM_TAIL   = 200;
    localparam int PHASES      = 6;

    logic                    clk;
    logic                    rst_n;
    logic                    item_valid;
    logic                    item_stall;
    logic [OP_W-1:0]         opcode;
    logic [CHAR_W-1:0]       char_code;
    logic [IDX_W-1:0]        cell_index;
    logic                    result_valid;
    logic                    result_stall;
    logic [IDX_W-1:0]        cursor_pos;
    logic [CELL_DATA_W-1:0]  cell_value;
    logic                    text_attribute_we;
    logic [ATTR_W-1:0]       text_attribute;

    int fail_count;
    int pending;
    int scroll_count;
    int cycle_count;
    int sent_total;
    int sent_by_op [4];
    int hold_left;
    bit quiet;
    bit sender_calm;

    text_console_writer u_top (.*);

    text_console_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: stall bursts and open stretches in random order
    always @(negedge clk)
    begin
        if (quiet || !rst_n)
            result_stall <= 1'b0;
        else if (hold_left == 0)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                result_stall <= 1'b1;
                hold_left = $urandom_range(1, 14);
            end
            else
            begin
                result_stall <= 1'b0;
                hold_left = $urandom_range(1, 40);
            end
        end
        else
            hold_left--;
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_item(input op_t op, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] idx);
        int gap;
        gap = 0;
        if (!quiet && !sender_calm && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 14);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        opcode     <= op;
        char_code  <= ch;
        cell_index <= idx;
        @(posedge clk);
        while (item_stall !== 1'b0)
            @(posedge clk);
        @(negedge clk);
        sent_total++;
        sent_by_op[op]++;
        if (sent_total >= ITEM_TARGET - CALM_TAIL)
            quiet = 1'b1;
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        text_attribute_we <= 1'b1;
        text_attribute    <= value;
        @(negedge clk);
        text_attribute_we <= 1'b0;
    endtask

    initial
    begin
        int phase;
        int kind;
        int run_len;
        int k;
        logic [ATTR_W-1:0] attr_value;

        rst_n             = 1'b0;
        item_valid        = 1'b0;
        opcode            = OP_WRITE;
        char_code         = '0;
        cell_index        = '0;
        text_attribute_we = 1'b0;
        text_attribute    = RESET_ATTR;
        quiet             = 1'b0;
        sender_calm       = 1'b1;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        // store is blanked after reset with stall high
        @(negedge clk);
        while (item_stall !== 1'b0)
            @(negedge clk);

        // directed beats under the reset attribute
        send_item(OP_BACKSPACE, 8'h00, 11'd0);      // backspace at the origin
        send_item(OP_READ, 8'hFF, 11'd0);           // reset blank
        send_item(OP_WRITE, 8'h00, 11'h7FF);
        send_item(OP_WRITE, 8'hFF, 11'd0);
        send_item(OP_WRITE, NEWLINE_CODE, 11'd5);
        send_item(OP_WRITE, 8'h41, 11'd0);
        send_item(OP_BACKSPACE, 8'hFF, 11'h7FF);
        send_item(OP_BACKSPACE, 8'h55, 11'd3);      // wraps to the end of row 0
        send_item(OP_READ, 8'h00, 11'd0);
        send_item(OP_READ, 8'h00, 11'd1);
        send_item(OP_READ, 8'h00, 11'd79);
        send_item(OP_READ, 8'h00, 11'd1999);
        send_item(OP_READ, 8'h00, 11'd2000);        // just outside the store
        send_item(OP_READ, 8'hAA, 11'h7FF);
        send_item(OP_WRITE, 8'h55, 11'd0);          // last column, line wrap
        send_item(OP_READ, 8'h00, 11'd79);
        send_item(OP_CLEAR, 8'h0A, 11'd12);
        send_item(OP_READ, 8'h00, 11'd1);
        send_item(OP_WRITE, 8'h80, 11'h400);
        send_item(OP_WRITE, 8'h7F, 11'h3FF);

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            if (phase == 0)
                attr_value = 8'hFF;
            else if (phase == 1)
                attr_value = 8'h00;
            else if (phase == PHASES - 1)
                attr_value = RESET_ATTR;
            else
                attr_value = ATTR_W'($urandom_range(0, 255));
            write_attribute(attr_value);
            while (sent_total < (phase + 1) * ITEM_TARGET / PHASES)
            begin
                sender_calm = ($urandom_range(0, 2) == 0);
                kind = $urandom_range(0, 99);
                if (kind < 45)
                begin
                    // text, now and then long enough to wrap a line
                    run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 90)
                                                          : $urandom_range(1, 20);
                    for (k = 0; k < run_len; k++)
                        send_item(OP_WRITE, CHAR_W'($urandom_range(0, 255)),
                                  IDX_W'($urandom_range(0, 2047)));
                    if ($urandom_range(0, 1) == 0)
                        send_item(OP_WRITE, NEWLINE_CODE, IDX_W'($urandom_range(0, 2047)));
                end
                else if (kind < 60)
                begin
                    run_len = $urandom_range(1, 6);
                    for (k = 0; k < run_len; k++)
                        send_item(OP_READ, CHAR_W'($urandom_range(0, 255)),
                                  IDX_W'(($urandom_range(0, 9) == 0)
                                         ? $urandom_range(2000, 2047)
                                         : $urandom_range(0, 1999)));
                end
                else if (kind < 75)
                begin
                    // a newline first makes the backspace step back over a row
                    if ($urandom_range(0, 1) == 0)
                        send_item(OP_WRITE, NEWLINE_CODE, IDX_W'($urandom_range(0, 2047)));
                    run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                          : $urandom_range(1, 6);
                    for (k = 0; k < run_len; k++)
                        send_item(OP_BACKSPACE, CHAR_W'($urandom_range(0, 255)),
                                  IDX_W'($urandom_range(0, 2047)));
                end
                else if (kind < 90)
                begin
                    run_len = $urandom_range(1, 3);
                    for (k = 0; k < run_len; k++)
                        send_item(OP_WRITE, NEWLINE_CODE, IDX_W'($urandom_range(0, 2047)));
                end
                else if (kind < 98)
                    send_item(op_t'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                              IDX_W'($urandom_range(0, 2047)));
                else if (kind == 98)
                    send_item(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
                              IDX_W'($urandom_range(0, 2047)));
                else if (!quiet)
                    drain_results();
            end
        end

        drain_results();
        repeat (20) @(negedge clk);

        $display("tb: %0d beats sent: %0d writes, %0d backspaces, %0d clears, %0d reads",
                 sent_total, sent_by_op[OP_WRITE], sent_by_op[OP_BACKSPACE],
                 sent_by_op[OP_CLEAR], sent_by_op[OP_READ]);
        $display("tb: %0d scrolls seen over %0d attribute settings, with random stalls",
                 scroll_count, PHASES + 1);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_sequencer.sv
rtl/tcw_datapath.sv
rtl/text_console_writer.sv
tb/text_console_checker.sv
tb/tb.sv
